>>> rtl/typed_nearest_marker_match_gate_assert.svh
// Assertion macros shared by the match gate RTL
`ifndef TYPED_NEAREST_MARKER_MATCH_GATE_ASSERT_SVH
`define TYPED_NEAREST_MARKER_MATCH_GATE_ASSERT_SVH

// implication in the same cycle
`define TNMG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("match gate assertion failed");

// implication into the next cycle
`define TNMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("match gate assertion failed");

`endif

>>> rtl/tnmg_pkg.sv
// Shared types and constants of the marker match gate
package tnmg_pkg;

  localparam int MAX_MARKERS = 64;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] CFG_ENTRY_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_SEARCH_RADIUS = 2'd1;
  localparam logic [1:0] CFG_GATE_XY       = 2'd2;
  localparam logic [1:0] CFG_GATE_THETA    = 2'd3;

  typedef struct packed {
    logic [7:0]  kind;
    logic [23:0] x;
    logic [23:0] y;
    logic [14:0] heading;
  } entry_t;

  typedef struct packed {
    logic       start;
    logic       step_valid;
    logic [5:0] step_index;
  } scan_ctl_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  index;
    logic [23:0] x;
    logic [23:0] y;
    logic [14:0] heading;
    logic        gate;
  } result_t;

endpackage

>>> rtl/typed_nearest_marker_match_gate.sv
// Top level of the typed nearest marker match gate
// A load word (tuser 0) writes one table slot and gives no result; a query
// word (tuser 1) turns the table ring once past a shared distance pipeline
// and gives one result word. Loads are taken back to back while idle. A
// query holds the input through the accepting cycle, the full turn of the
// ring that brings every cell back to its home slot, and the drain of the
// distance and compare pipeline before the result moves to the output
// register. The result waits there, so loads and the next query are taken
// while it is still unclaimed; a query that finishes while the previous
// result still waits holds the input until that result is taken.
module typed_nearest_marker_match_gate
  import tnmg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index, meas_type, meas_x, meas_y, meas_heading, zero pad
  input  logic [79:0] s_tdata,
  // mode
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found, match_index, match_x, match_y, match_heading, within_gate, zero pad
  output logic [71:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  `include "typed_nearest_marker_match_gate_assert.svh"

  localparam int CW = $clog2(MAX_MARKERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t      st;
  state_t      st_next;
  logic [CW-1:0] step;
  logic [CW-1:0] count_lim;

  logic [6:0]  entry_limit;
  logic [23:0] search_radius;
  logic [23:0] gate_xy;
  logic [14:0] gate_theta;

  logic        in_accept;
  logic        in_query;
  logic        in_load;
  logic [5:0]  in_index;
  entry_t      in_entry;
  entry_t      query;
  entry_t      ring [MAX_MARKERS];
  scan_ctl_t   ctl;
  result_t     result;
  result_t     out_res;
  logic        busy;
  logic        deliver;

  assign in_index         = s_tdata[5:0];
  assign in_entry.kind    = s_tdata[13:6];
  assign in_entry.x       = s_tdata[37:14];
  assign in_entry.y       = s_tdata[61:38];
  assign in_entry.heading = s_tdata[76:62];

  assign s_tready  = (st == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_query  = in_accept && (s_tuser[0] == MODE_QUERY);
  assign in_load   = in_accept && (s_tuser[0] == MODE_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit   <= 7'd0;
      search_radius <= 24'd256000;
      gate_xy       <= 24'd512;
      gate_theta    <= 15'd2145;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRY_LIMIT:   entry_limit   <= cfg_data[6:0];
        CFG_SEARCH_RADIUS: search_radius <= cfg_data;
        CFG_GATE_XY:       gate_xy       <= cfg_data;
        CFG_GATE_THETA:    gate_theta    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(entry_limit) > MAX_MARKERS) begin
      count_lim = CW'(MAX_MARKERS);
    end else begin
      count_lim = CW'(entry_limit);
    end
  end

  for (genvar i = 0; i < MAX_MARKERS; i++) begin : g_ring
    tnmg_cell u_cell (
      .clk        (clk),
      .load_en    (in_load && ({26'd0, in_index} == 32'(i))),
      .load_entry (in_entry),
      .shift_en   (st == ST_SCAN),
      .prev_entry (ring[(i + 1) % MAX_MARKERS]),
      .entry      (ring[i])
    );
  end

  always_ff @(posedge clk) begin
    if (in_query) begin
      query <= in_entry;
    end
  end

  assign ctl.start      = in_query;
  assign ctl.step_valid = (st == ST_SCAN) && (step < count_lim);
  assign ctl.step_index = 6'(step);

  tnmg_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .head          (ring[0]),
    .query         (query),
    .search_radius (search_radius),
    .gate_xy       (gate_xy),
    .gate_theta    (gate_theta),
    .busy          (busy),
    .result        (result)
  );

  assign deliver = (st == ST_FLUSH) && !busy && (!m_tvalid || m_tready);

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (in_query) begin
          st_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step == CW'(MAX_MARKERS - 1)) begin
          st_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (deliver) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      step <= '0;
    end else begin
      st <= st_next;
      if (st == ST_SCAN && st_next == ST_SCAN) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (deliver) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_res <= result;
    end
  end

  assign m_tdata = {1'b0, out_res.gate, out_res.heading, out_res.y, out_res.x,
                    out_res.index, out_res.found};

  `TNMG_ASSERT_IMPL(a_ring_home, st != ST_SCAN, step == '0)
  `TNMG_ASSERT_NEXT(a_deliver_sets_valid, deliver, m_tvalid)
  `TNMG_ASSERT_IMPL(a_valid_from_flush, $rose(m_tvalid), $past(st == ST_FLUSH))

endmodule

>>> rtl/tnmg_cell.sv
// One table cell of the rotating marker ring
module tnmg_cell
  import tnmg_pkg::*;
(
  input  logic   clk,
  input  logic   load_en,
  input  entry_t load_entry,
  input  logic   shift_en,
  input  entry_t prev_entry,
  output entry_t entry
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      entry <= load_entry;
    end else if (shift_en) begin
      entry <= prev_entry;
    end
  end

endmodule

>>> rtl/tnmg_scan.sv
// Distance, gate and best-match pipeline at the head of the ring
module tnmg_scan
  import tnmg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  scan_ctl_t   ctl,
  input  entry_t      head,
  input  entry_t      query,
  input  logic [23:0] search_radius,
  input  logic [23:0] gate_xy,
  input  logic [14:0] gate_theta,
  output logic        busy,
  output result_t     result
);

  `include "typed_nearest_marker_match_gate_assert.svh"

  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [15:0] dh;
  logic [23:0]        abs_x;
  logic [23:0]        abs_y;
  logic [14:0]        abs_h;

  logic        a_valid;
  logic [23:0] a_ax;
  logic [23:0] a_ay;
  logic [14:0] a_ah;
  logic [5:0]  a_index;
  entry_t      a_entry;

  logic        b_valid;
  logic [47:0] b_sqx;
  logic [47:0] b_sqy;
  logic        b_gate;
  logic [5:0]  b_index;
  entry_t      b_entry;

  logic [48:0] d2;
  logic [48:0] best;

  assign dx = $signed({head.x[23], head.x}) - $signed({query.x[23], query.x});
  assign dy = $signed({head.y[23], head.y}) - $signed({query.y[23], query.y});
  assign dh = $signed({head.heading[14], head.heading})
            - $signed({query.heading[14], query.heading});

  assign abs_x = dx[24] ? 24'(-dx) : 24'(dx);
  assign abs_y = dy[24] ? 24'(-dy) : 24'(dy);
  assign abs_h = dh[15] ? 15'(-dh) : 15'(dh);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= ctl.step_valid && (head.kind == query.kind);
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_ax    <= abs_x;
    a_ay    <= abs_y;
    a_ah    <= abs_h;
    a_index <= ctl.step_index;
    a_entry <= head;
    b_sqx   <= 48'(a_ax) * 48'(a_ax);
    b_sqy   <= 48'(a_ay) * 48'(a_ay);
    b_gate  <= (a_ax < gate_xy) && (a_ay < gate_xy) && (a_ah < gate_theta);
    b_index <= a_index;
    b_entry <= a_entry;
  end

  assign d2 = 49'(b_sqx) + 49'(b_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.found   <= 1'b0;
      result.gate    <= 1'b0;
    end else if (ctl.start) begin
      best           <= 49'(48'(search_radius) * 48'(search_radius));
      result.found   <= 1'b0;
      result.index   <= '0;
      result.x       <= '0;
      result.y       <= '0;
      result.heading <= '0;
      result.gate    <= 1'b0;
    end else if (b_valid && (d2 < best)) begin
      best           <= d2;
      result.found   <= 1'b1;
      result.index   <= b_index;
      result.x       <= b_entry.x;
      result.y       <= b_entry.y;
      result.heading <= b_entry.heading;
      result.gate    <= b_gate;
    end
  end

  assign busy = a_valid || b_valid;

  `TNMG_ASSERT_NEXT(a_start_clears, ctl.start, !result.found && !result.gate)
  `TNMG_ASSERT_NEXT(a_pipe_advance, a_valid, b_valid)
  `TNMG_ASSERT_IMPL(a_gate_needs_found, result.gate, result.found)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the typed nearest marker match gate, scored by a table predictor
module tb_top;
  import tnmg_pkg::*;

  localparam int SLOTS       = 64;
  localparam int SCAN_CYCLES = SLOTS + 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              found;
    logic [5:0]        index;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [14:0] heading;
    logic              gate;
  } match_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // predictor copy of the map table and registers
  logic [7:0]         map_kind[SLOTS];
  logic signed [23:0] map_x[SLOTS];
  logic signed [23:0] map_y[SLOTS];
  logic signed [14:0] map_heading[SLOTS];
  logic [6:0]         count_reg = 7'd0;
  logic [23:0]        radius_reg = 24'd256000;
  logic [23:0]        gate_xy_reg = 24'd512;
  logic [14:0]        gate_th_reg = 15'd2145;

  match_t pending_matches[$];
  int     errors = 0;
  int     cycles = 0;
  bit     no_idle = 1'b0;

  typed_nearest_marker_match_gate dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 21);
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int rand_kind();
    return ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 3)) :
                                          int'($urandom_range(0, 255));
  endfunction

  function automatic int rand_heading();
    return int'($urandom_range(0, 25736)) - 12868;
  endfunction

  function automatic int clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic match_t nearest_match(logic [7:0] kind, logic signed [23:0] mx,
                                           logic signed [23:0] my, logic signed [14:0] mh);
    match_t r;
    longint best, dx, dy, d2;
    int     n, i;
    r = '0;
    n = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
    best = longint'(radius_reg) * longint'(radius_reg);
    for (i = 0; i < n; i++) begin
      if (map_kind[i] == kind) begin
        dx = longint'(map_x[i]) - longint'(mx);
        dy = longint'(map_y[i]) - longint'(my);
        d2 = dx * dx + dy * dy;
        if (d2 < best) begin
          best = d2;
          r.found = 1'b1;
          r.index = 6'(i);
        end
      end
    end
    if (r.found) begin
      r.x = map_x[r.index];
      r.y = map_y[r.index];
      r.heading = map_heading[r.index];
      r.gate = mag(longint'(r.x) - longint'(mx)) < longint'(gate_xy_reg) &&
               mag(longint'(r.y) - longint'(my)) < longint'(gate_xy_reg) &&
               mag(longint'(r.heading) - longint'(mh)) < longint'(gate_th_reg);
    end
    return r;
  endfunction

  // hold the word until taken, then advance the predictor
  task automatic send_word(input logic mode, input int slot, input int kind,
                           input int xv, input int yv, input int hv);
    logic [5:0]         s6;
    logic [7:0]         k8;
    logic signed [23:0] x24, y24;
    logic signed [14:0] h15;
    s6 = 6'(slot);
    k8 = 8'(kind);
    x24 = 24'(xv);
    y24 = 24'(yv);
    h15 = 15'(hv);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {3'b000, h15, y24, x24, k8, s6};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_LOAD) begin
      map_kind[s6] = k8;
      map_x[s6] = x24;
      map_y[s6] = y24;
      map_heading[s6] = h15;
    end else begin
      pending_matches.push_back(nearest_match(k8, x24, y24, h15));
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENTRY_LIMIT:   count_reg = val[6:0];
      CFG_SEARCH_RADIUS: radius_reg = val;
      CFG_GATE_XY:       gate_xy_reg = val;
      CFG_GATE_THETA:    gate_th_reg = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int count, input int radius, input int gxy, input int gth);
    settle();
    set_reg(CFG_ENTRY_LIMIT, 24'(count));
    set_reg(CFG_SEARCH_RADIUS, 24'(radius));
    set_reg(CFG_GATE_XY, 24'(gxy));
    set_reg(CFG_GATE_THETA, 24'(gth));
  endtask

  // mostly words close to a table entry, the rest noise
  task automatic random_marker_word(input int load_pct);
    int n, j, span, kind, xv, yv, hv;
    n = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
    span = (gate_xy_reg > 10000) ? 20000 : int'(gate_xy_reg) * 2 + 16;
    kind = rand_kind();
    xv = int'($urandom);
    yv = int'($urandom);
    hv = rand_heading();
    if (n > 0 && $urandom_range(0, 99) < 75) begin
      j = $urandom_range(0, n - 1);
      if ($urandom_range(0, 9) != 0) kind = int'(map_kind[j]);
      xv = clamp24(longint'(map_x[j]) + jitter(span));
      yv = clamp24(longint'(map_y[j]) + jitter(span));
      hv = int'(map_heading[j]) + jitter(3000);
      if (hv > 12868) hv = 12868;
      if (hv < -12868) hv = -12868;
    end
    if ($urandom_range(0, 99) < load_pct)
      send_word(MODE_LOAD, $urandom_range(0, 63), kind, xv, yv, hv);
    else
      send_word(MODE_QUERY, $urandom_range(0, 63), kind, xv, yv, hv);
  endtask

  task automatic test_empty_table();
    settle();
    send_word(MODE_QUERY, 0, 5, 0, 0, 0);
    send_word(MODE_QUERY, 63, 255, -1, -1, -1);
  endtask

  task automatic test_directed_cases();
    send_word(MODE_LOAD, 0, 5, 1000, 1000, 100);
    send_word(MODE_LOAD, 1, 5, 1200, 1000, -100);
    send_word(MODE_LOAD, 2, 7, 1100, 1000, 0);
    send_word(MODE_LOAD, 3, 255, 8388607, -8388608, 12868);
    send_word(MODE_LOAD, 4, 0, -8388608, 8388607, -12868);
    send_word(MODE_LOAD, 5, 5, 5000, 5000, 0);
    send_word(MODE_LOAD, 63, 200, 0, 0, 0);
    set_all(6, 256000, 512, 2145);
    // equal distance to slots 0 and 1: lowest slot wins
    send_word(MODE_QUERY, 0, 5, 1100, 1000, 0);
    send_word(MODE_QUERY, 0, 7, 1100, 1000, 0);
    // heading offset taken without wrap
    send_word(MODE_QUERY, 0, 255, 8388607, -8388608, -12868);
    send_word(MODE_QUERY, 0, 0, -8388608, 8388607, 12868);
    send_word(MODE_QUERY, 0, 9, 1000, 1000, 100);
    send_word(MODE_QUERY, 0, 5, 5600, 5000, 0);
    send_word(MODE_QUERY, 0, 255, 0, 0, 0);
    set_all(6, 0, 512, 2145);
    send_word(MODE_QUERY, 0, 5, 1000, 1000, 100);
    set_all(6, 16777215, 16777215, 25736);
    send_word(MODE_QUERY, 0, 255, -8388608, 8388607, 0);
    send_word(MODE_QUERY, 0, 0, 8388607, -8388608, 0);
    send_word(MODE_QUERY, 0, 255, 0, 0, 0);
    send_word(MODE_QUERY, 0, 5, 1100, 1000, -12868);
  endtask

  task automatic test_full_table();
    int i;
    for (i = 0; i < SLOTS; i++)
      send_word(MODE_LOAD, i, $urandom_range(0, 3), jitter(4000), jitter(4000),
                rand_heading());
    set_all(64, 256000, 512, 2145);
    repeat (10) random_marker_word(0);
    // count above capacity is clamped
    set_all(127, 256000, 512, 2145);
    repeat (5) random_marker_word(0);
    set_all(65, 3000, 1000, 4000);
    repeat (5) random_marker_word(0);
    set_all(64, 16777215, 16777215, 25736);
    repeat (5) random_marker_word(0);
    set_all(64, 16777215, 0, 0);
    repeat (5) random_marker_word(0);
  endtask

  task automatic test_random_traffic();
    int counts[5]  = '{64, 17, 1, 40, 0};
    int radii[5]   = '{256000, 4096, 16777215, 700, 0};
    int gates[5]   = '{512, 2048, 16777215, 300, 0};
    int thetas[5]  = '{2145, 8000, 25736, 500, 0};
    int p;
    for (p = 0; p < 5; p++) begin
      if (p == 4)
        set_all($urandom_range(1, 64), $urandom_range(0, 30000),
                $urandom_range(0, 4000), $urandom_range(0, 25736));
      else
        set_all(counts[p], radii[p], gates[p], thetas[p]);
      no_idle = (p == 0);
      repeat (80) random_marker_word(30);
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    match_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.found   = m_tdata[0];
      got.index   = m_tdata[6:1];
      got.x       = m_tdata[30:7];
      got.y       = m_tdata[54:31];
      got.heading = m_tdata[69:55];
      got.gate    = m_tdata[70];
      if (pending_matches.size() == 0) begin
        errors++;
        $error("result word with no query waiting");
      end else begin
        want = pending_matches.pop_front();
        if (got.found !== want.found) begin
          errors++;
          $error("found: expected %0d, got %0d", want.found, got.found);
        end
        if (got.index !== want.index) begin
          errors++;
          $error("match_index: expected %0d, got %0d", want.index, got.index);
        end
        if (got.x !== want.x) begin
          errors++;
          $error("match_x: expected %0d, got %0d", want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++;
          $error("match_y: expected %0d, got %0d", want.y, got.y);
        end
        if (got.heading !== want.heading) begin
          errors++;
          $error("match_heading: expected %0d, got %0d", want.heading, got.heading);
        end
        if (got.gate !== want.gate) begin
          errors++;
          $error("within_gate: expected %0d, got %0d", want.gate, got.gate);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_cases();
    test_full_table();
    test_random_traffic();
    settle();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> typed_nearest_marker_match_gate.f
+incdir+rtl
rtl/tnmg_pkg.sv
rtl/tnmg_cell.sv
rtl/tnmg_scan.sv
rtl/typed_nearest_marker_match_gate.sv
test/tb_top.sv
